// ===== rtl/core/mpfc_pkg.sv =====
// mpfc_pkg: shared types and constants for the fan speed regulator
// used by all modules under rtl/core
package mpfc_pkg;

  typedef enum logic [3:0] {
    ACT_CYCLE  = 4'd0,
    ACT_TICK   = 4'd1,
    ACT_SET    = 4'd2,
    ACT_NEXT   = 4'd3,
    ACT_AUTO   = 4'd4,
    ACT_MANUAL = 4'd5,
    ACT_TOGGLE = 4'd6,
    ACT_DOWN   = 4'd7,
    ACT_UP     = 4'd8,
    ACT_OFF    = 4'd9,
    ACT_ON     = 4'd10
  } action_t;

  typedef enum logic [2:0] {
    CFG_GAIN_P = 3'd0,
    CFG_GAIN_I = 3'd1,
    CFG_GAIN_D = 3'd2,
    CFG_DEADBAND = 3'd3,
    CFG_TIMEOUT = 3'd4,
    CFG_LIMIT = 3'd5,
    CFG_TMAX = 3'd6,
    CFG_MUNIT = 3'd7
  } cfg_idx_t;

  // one queued command from the front end
  typedef struct packed {
    logic [3:0]       action;
    logic signed [8:0] sample;
    logic             ok;
    logic [3:0]       step_value;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic [3:0]        step_size;
    logic              system_off;
    logic              fault_timeout;
    logic              mode_manual;
    logic [7:0]        target_level;
    logic signed [8:0] median_pressure;
    logic [14:0]       speed_command;
  } res_t;

  typedef struct packed {
    logic [14:0] gain_p;
    logic [14:0] gain_i;
    logic [14:0] gain_d;
    logic [3:0]  deadband;
    logic [15:0] timeout_ticks;
    logic [14:0] speed_limit;
    logic [7:0]  target_max;
    logic [11:0] manual_unit;
  } cfg_t;

endpackage

// ===== rtl/core/median_pid_pressure_fan_control.sv =====
// median_pid_pressure_fan_control: top level of the fan speed regulator
// depends on mpfc_pkg, mpfc_front, mpfc_back
//
// channel   dir  payload
// s_axis    in   tdata: action[3:0] sample[12:4] ok[13] step_value[17:14]
// m_axis    out  tdata: speed[14:0] median[23:15] target[31:24] manual[32]
//                       fault[33] off[34] step[38:35]
// cfg       in   index[2:0], data[15:0]
//
// sequence: a plain event passes S_IDLE, S_OUT and S_HOLD, a manual nudge adds S_SUM, and a control
// cycle can add S_MUL0 to S_MUL2 on the shared multiplier, S_SUM and the one-candidate-a-cycle S_RANK median scan.
// reset: synchronous, restores all register and state reset values except the queue memory.
// stalls: a two-beat queue lets input beats land while a result waits.
module median_pid_pressure_fan_control
  import mpfc_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // action, pressure_sample, sample_ok, step_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // speed_command, median_pressure, target_level,
                                      // mode_manual, fault_timeout, system_off, step_size
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{gain_p: 15'd120, gain_i: 15'd10, gain_d: 15'd100, deadband: 4'd1,
               timeout_ticks: 16'd15000, speed_limit: 15'd20000, target_max: 8'd128,
               manual_unit: 12'd1000};
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P:   cfg.gain_p <= cfg_data[14:0];
        CFG_GAIN_I:   cfg.gain_i <= cfg_data[14:0];
        CFG_GAIN_D:   cfg.gain_d <= cfg_data[14:0];
        CFG_DEADBAND: cfg.deadband <= cfg_data[3:0];
        CFG_TIMEOUT:  cfg.timeout_ticks <= cfg_data;
        CFG_LIMIT:    cfg.speed_limit <= cfg_data[14:0];
        CFG_TMAX:     cfg.target_max <= cfg_data[7:0];
        CFG_MUNIT:    cfg.manual_unit <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign in_cmd.action     = s_axis_tdata[3:0];
  assign in_cmd.sample     = s_axis_tdata[12:4];
  assign in_cmd.ok         = s_axis_tdata[13];
  assign in_cmd.step_value = s_axis_tdata[17:14];

  mpfc_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  mpfc_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_ready(q_ready),
    .q_cmd(q_cmd), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {1'b0, res};

  // checks
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[14:0] == 15'd0)
    else $error("speed nonzero while off");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(u_back.fault) |-> u_back.fault)
    else $error("fault cleared");

endmodule

// ===== rtl/core/mpfc_front.sv =====
// mpfc_front: input capture and command queue
// depends on mpfc_pkg
module mpfc_front
  import mpfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cmd_t        in_cmd,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);

  // two-entry queue
  cmd_t        mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/mpfc_back.sv =====
// mpfc_back: control sequencer, pid with one shared multiplier, median select
// depends on mpfc_pkg
module mpfc_back
  import mpfc_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 11
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int unsigned IdxW = $clog2(WINDOW_LEN);
  localparam int unsigned Mid  = WINDOW_LEN / 2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL0 = 8'b0000_0010,
    S_MUL1 = 8'b0000_0100,
    S_MUL2 = 8'b0000_1000,
    S_SUM  = 8'b0001_0000,
    S_RANK = 8'b0010_0000,
    S_OUT  = 8'b0100_0000,
    S_HOLD = 8'b1000_0000
  } state_t;

  state_t state;
  state_t idle_next;

  logic signed [8:0]  window [WINDOW_LEN];
  logic signed [8:0]  median;
  logic [7:0]         target;
  logic [14:0]        speed;
  logic signed [15:0] integ;
  logic signed [10:0] prev_err;
  logic [15:0]        tleft;
  logic               manual, fault, off_f;
  logic [3:0]         step;
  cmd_t               cmd;

  logic signed [10:0] err;
  logic signed [11:0] deriv;
  logic signed [16:0] integ_sum;
  logic signed [15:0] integ_sat;
  logic [10:0]        mag;
  logic signed [47:0] acc;
  logic signed [31:0] prod;
  logic signed [15:0] mul_a;
  logic [14:0]        mul_b;
  logic               take;
  logic [IdxW-1:0]    cand;
  logic [IdxW:0]      n_less, n_leq;
  logic [15:0]        delta;
  logic signed [17:0] spd_sum;

  assign err       = $signed({3'b000, target}) - 11'(median);
  assign mag       = err[10] ? 11'(-err) : err;
  assign deriv     = 12'(err) - 12'(prev_err);
  assign integ_sum = 17'(integ) + 17'(err);
  assign integ_sat = (integ_sum > 17'sd32767) ? 16'sh7fff :
                     (integ_sum < -17'sd32768) ? 16'sh8000 : integ_sum[15:0];
  assign delta     = 16'(step) * 16'(cfg.manual_unit);

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      S_MUL0:  begin mul_a = 16'(err);      mul_b = cfg.gain_p; end
      S_MUL1:  begin mul_a = integ;         mul_b = cfg.gain_i; end
      default: begin mul_a = 16'(deriv);    mul_b = cfg.gain_d; end
    endcase
  end
  assign prod = mul_a * $signed({1'b0, mul_b});

  // rank count for one median candidate
  always_comb begin
    n_less = '0;
    n_leq  = '0;
    for (int k = 0; k < WINDOW_LEN; k++) begin
      n_less = n_less + (IdxW+1)'(window[k] < window[cand]);
      n_leq  = n_leq + (IdxW+1)'(window[k] <= window[cand]);
    end
  end

  // manual speed nudge
  always_comb begin
    if (cmd.action == ACT_DOWN) spd_sum = 18'(speed) - 18'(delta);
    else                         spd_sum = 18'(speed) + 18'(delta);
  end

  // where an accepted command goes next
  always_comb begin
    idle_next = S_OUT;
    if (q_cmd.action == ACT_CYCLE && !off_f) begin
      if (!manual && mag > 11'(cfg.deadband) && !fault) idle_next = S_MUL0;
      else idle_next = S_SUM;
    end else if ((q_cmd.action == ACT_DOWN || q_cmd.action == ACT_UP) && !off_f && manual) begin
      idle_next = S_SUM;
    end
  end

  assign q_ready   = (state == S_IDLE);
  assign res_valid = (state == S_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < WINDOW_LEN; k++) window[k] <= '0;
      median <= '0; target <= 8'd40; speed <= '0; integ <= '0;
      prev_err <= '0; tleft <= 16'd15000; manual <= 1'b0; fault <= 1'b0;
      off_f <= 1'b0; step <= 4'd1; take <= 1'b0; cand <= '0; acc <= '0;
      cmd <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd   <= q_cmd;
            state <= idle_next;
            case (q_cmd.action)
              ACT_CYCLE: begin
                take <= q_cmd.ok && !off_f;
                if (off_f) begin
                  integ <= '0; prev_err <= '0; tleft <= cfg.timeout_ticks;
                end else if (!manual && mag <= 11'(cfg.deadband)) begin
                  tleft <= cfg.timeout_ticks;
                end
              end
              ACT_TICK: if (tleft != 0) tleft <= tleft - 16'd1;
              ACT_SET: if (q_cmd.step_value >= 4'd1 && q_cmd.step_value <= 4'd10)
                step <= q_cmd.step_value;
              ACT_NEXT: if (!off_f) step <= (step + 4'd1 >= 4'd4) ? 4'd1 : step + 4'd1;
              ACT_AUTO: if (manual) begin
                manual <= 1'b0; speed <= '0; integ <= '0; prev_err <= '0;
                tleft <= cfg.timeout_ticks;
              end
              ACT_MANUAL: if (!manual) begin
                manual <= 1'b1; speed <= '0; integ <= '0; prev_err <= '0;
              end
              ACT_TOGGLE: if (!off_f) begin
                speed <= '0; integ <= '0; prev_err <= '0;
                if (manual) tleft <= cfg.timeout_ticks;
                manual <= ~manual;
              end
              ACT_DOWN, ACT_UP: if (!off_f) begin
                // manual speed nudge is handled next cycle in S_SUM
                if (!manual) begin
                  if (q_cmd.action == ACT_DOWN)
                    target <= (target < 8'(step)) ? 8'd0 : target - 8'(step);
                  else if (9'(target) + 9'(step) > 9'(cfg.target_max))
                    target <= cfg.target_max;
                  else target <= target + 8'(step);
                end
              end
              ACT_OFF: off_f <= 1'b1;
              ACT_ON:  off_f <= 1'b0;
              default: ;
            endcase
          end
        end
        S_MUL0: begin acc <= 48'(prod); state <= S_MUL1; integ <= integ_sat; end
        S_MUL1: begin acc <= acc + 48'(prod); state <= S_MUL2; end
        S_MUL2: begin
          acc <= acc + 48'(prod);
          prev_err <= err;
          state <= S_SUM;
        end
        S_SUM: begin
          cand <= '0;
          if (cmd.action == ACT_CYCLE) begin
            if (!manual && !fault && mag > 11'(cfg.deadband)) begin
              if (tleft == 0) begin
                fault <= 1'b1; speed <= '0; integ <= '0;
              end else if (acc < 0) speed <= '0;
              else if (acc > 48'(cfg.speed_limit)) speed <= cfg.speed_limit;
              else speed <= acc[14:0];
            end
            if (manual) tleft <= cfg.timeout_ticks;
            if (take) begin
              for (int k = 0; k < WINDOW_LEN - 1; k++) window[k] <= window[k+1];
              window[WINDOW_LEN-1] <= cmd.sample;
              state <= S_RANK;
            end else state <= S_OUT;
          end else begin
            if (spd_sum < 0) speed <= '0;
            else if (spd_sum > 18'(cfg.speed_limit)) speed <= cfg.speed_limit;
            else speed <= spd_sum[14:0];
            state <= S_OUT;
          end
        end
        // one candidate per cycle: at most Mid entries below it, more than Mid at or below
        S_RANK: begin
          if (n_less <= (IdxW+1)'(Mid) && n_leq > (IdxW+1)'(Mid)) begin
            median <= window[cand];
            state  <= S_OUT;
          end else cand <= cand + 1'b1;
        end
        S_OUT: state <= S_HOLD;
        S_HOLD: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.speed_command   = off_f ? 15'd0 : speed;
  assign res.median_pressure = median;
  assign res.target_level    = target;
  assign res.mode_manual     = manual;
  assign res.fault_timeout   = fault;
  assign res.system_off      = off_f;
  assign res.step_size       = step;

endmodule

// ===== bench/mpfc_checker.sv =====
// mpfc_checker: watches the command, result and register channels of the fan regulator,
// predicts every result beat and compares it field by field; depends on mpfc_pkg
module mpfc_checker
  import mpfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // action, pressure_sample, sample_ok, step_value
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // speed_command, median_pressure, target_level,
                                      // mode_manual, fault_timeout, system_off, step_size
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Win = 11;

  // register copy
  int kp, ki, kd, band, tmo_ticks, spd_lim, tgt_max, man_unit;
  // regulator state copy
  int win_q[Win];
  int med, tgt, spd, integ, prev_err, tmo_left, step;
  bit manual, fault, off;

  res_t expected_beats[$];

  function automatic int clamp_spd(longint v);
    if (v > spd_lim) return spd_lim;
    if (v < 0) return 0;
    return int'(v);
  endfunction

  // shift a sample in and recompute the median
  task automatic push_sample(int s);
    int srt[Win];
    int v, j;
    for (int i = 0; i < Win - 1; i++) win_q[i] = win_q[i + 1];
    win_q[Win - 1] = s;
    srt = win_q;
    for (int i = 1; i < Win; i++) begin
      v = srt[i];
      j = i;
      while (j > 0 && srt[j - 1] > v) begin
        srt[j] = srt[j - 1];
        j--;
      end
      srt[j] = v;
    end
    med = srt[Win / 2];
  endtask

  task automatic run_cycle(int s, bit ok);
    int diff, mag, deriv;
    longint sum;
    if (off) begin
      integ = 0;
      prev_err = 0;
      tmo_left = tmo_ticks;
      return;
    end
    if (!manual) begin
      diff = tgt - med;
      mag = diff < 0 ? -diff : diff;
      if (mag > band) begin
        if (!fault) begin
          deriv = diff - prev_err;
          integ += diff;
          if (integ > 32767) integ = 32767;
          if (integ < -32768) integ = -32768;
          prev_err = diff;
          sum = longint'(kp) * diff + longint'(ki) * integ + longint'(kd) * deriv;
          spd = clamp_spd(sum);
          if (tmo_left == 0) begin
            fault = 1;
            spd = 0;
            integ = 0;
          end
        end
      end else begin
        tmo_left = tmo_ticks;
      end
    end
    if (ok) push_sample(s);
    if (manual) tmo_left = tmo_ticks;
  endtask

  task automatic loop_clear();
    spd = 0;
    integ = 0;
    prev_err = 0;
  endtask

  // one command in, one expected result out
  task automatic predict_result(logic [23:0] d, output res_t r);
    logic [3:0] act;
    int s, sv, delta;
    act = d[3:0];
    s = int'($signed(d[12:4]));
    sv = d[17:14];
    delta = step * man_unit;
    case (act)
      ACT_CYCLE: run_cycle(s, d[13]);
      ACT_TICK: if (tmo_left > 0) tmo_left--;
      ACT_SET: if (sv >= 1 && sv <= 10) step = sv;
      ACT_NEXT: if (!off) begin
        step++;
        if (step >= 4) step = 1;
      end
      ACT_AUTO: if (manual) begin
        manual = 0;
        loop_clear();
        tmo_left = tmo_ticks;
      end
      ACT_MANUAL: if (!manual) begin
        manual = 1;
        loop_clear();
      end
      ACT_TOGGLE: if (!off) begin
        loop_clear();
        if (manual) tmo_left = tmo_ticks;
        manual = !manual;
      end
      ACT_DOWN: if (!off) begin
        if (!manual) begin
          tgt -= step;
          if (tgt < 0) tgt = 0;
        end else spd = clamp_spd(longint'(spd) - delta);
      end
      ACT_UP: if (!off) begin
        if (!manual) begin
          tgt += step;
          if (tgt > tgt_max) tgt = tgt_max;
        end else spd = clamp_spd(longint'(spd) + delta);
      end
      ACT_OFF: off = 1;
      ACT_ON: off = 0;
      default: ;
    endcase
    r.speed_command   = off ? 15'd0 : spd[14:0];
    r.median_pressure = med[8:0];
    r.target_level    = tgt[7:0];
    r.mode_manual     = manual;
    r.fault_timeout   = fault;
    r.system_off      = off;
    r.step_size       = step[3:0];
  endtask

  // channel monitor
  always @(posedge clk) begin
    res_t exp_r, got;
    if (rst) begin
      kp = 120; ki = 10; kd = 100; band = 1;
      tmo_ticks = 15000; spd_lim = 20000; tgt_max = 128; man_unit = 1000;
      foreach (win_q[i]) win_q[i] = 0;
      med = 0; tgt = 40; spd = 0; integ = 0; prev_err = 0;
      tmo_left = 15000; manual = 0; fault = 0; off = 0; step = 1;
      expected_beats.delete();
      errors <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_GAIN_P:   kp = cfg_data[14:0];
          CFG_GAIN_I:   ki = cfg_data[14:0];
          CFG_GAIN_D:   kd = cfg_data[14:0];
          CFG_DEADBAND: band = cfg_data[3:0];
          CFG_TIMEOUT:  tmo_ticks = cfg_data;
          CFG_LIMIT:    spd_lim = cfg_data[14:0];
          CFG_TMAX:     tgt_max = cfg_data[7:0];
          CFG_MUNIT:    man_unit = cfg_data[11:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_result(s_axis_tdata, exp_r);
        expected_beats.push_back(exp_r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[38:0]);
        results_seen <= results_seen + 1;
        if (expected_beats.size() == 0) begin
          if (errors < 10) $display("result beat with nothing expected: %h", m_axis_tdata);
          errors <= errors + 1;
        end else begin
          exp_r = expected_beats.pop_front();
          if (got.speed_command !== exp_r.speed_command ||
              got.median_pressure !== exp_r.median_pressure ||
              got.target_level !== exp_r.target_level ||
              got.mode_manual !== exp_r.mode_manual ||
              got.fault_timeout !== exp_r.fault_timeout ||
              got.system_off !== exp_r.system_off ||
              got.step_size !== exp_r.step_size) begin
            if (errors < 10)
              $display("mismatch beat %0d: exp spd=%0d med=%0d tgt=%0d man=%b flt=%b",
                       results_seen, exp_r.speed_command, exp_r.median_pressure,
                       exp_r.target_level, exp_r.mode_manual, exp_r.fault_timeout,
                       " off=%b stp=%0d | got spd=%0d med=%0d tgt=%0d man=%b flt=%b",
                       exp_r.system_off, exp_r.step_size, got.speed_command,
                       got.median_pressure, got.target_level, got.mode_manual,
                       got.fault_timeout, " off=%b stp=%0d",
                       got.system_off, got.step_size);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_beats.size();
    end
  end
endmodule

// ===== bench/tb_median_pid_pressure_fan_control.sv =====
// tb_median_pid_pressure_fan_control: stimulus and verdict for the fan regulator
// depends on mpfc_pkg, the regulator RTL and mpfc_checker
module tb_median_pid_pressure_fan_control;
  import mpfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int errors, pending, results_seen;
  int send_idle = 34;
  int recv_idle = 53;
  int sent = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  median_pid_pressure_fan_control DUT (.*);

  mpfc_checker u_checker (.*);

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side backpressure
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle);

  // one command beat, held until accepted
  task automatic send_cmd(action_t act, int s, bit ok, int sv);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, sv[3:0], ok, s[8:0], act};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
    // idling schedule across the run
    if (sent == 520) begin
      send_idle = 53;
      recv_idle = 34;
    end else if (sent == 1040) begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  // register write once the regulator has gone quiet
  task automatic write_reg(cfg_idx_t idx, int val);
    @(negedge clk);
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic write_all(int p, int i, int d, int db, int tmo, int lim, int tmax, int mu);
    write_reg(CFG_GAIN_P, p);
    write_reg(CFG_GAIN_I, i);
    write_reg(CFG_GAIN_D, d);
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_LIMIT, lim);
    write_reg(CFG_TMAX, tmax);
    write_reg(CFG_MUNIT, mu);
  endtask

  // random mix weighted toward control cycles with samples near the target
  task automatic random_cmds(int n, int centre);
    int r, s;
    action_t act;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 45) act = ACT_CYCLE;
      else if (r < 60) act = ACT_TICK;
      else if (r < 62) act = ACT_OFF;
      else if (r < 66) act = ACT_ON;
      else act = action_t'($urandom_range(2, 8));
      if ($urandom_range(9) == 0) act = action_t'($urandom_range(15));
      if ($urandom_range(4) == 0) s = int'($urandom_range(511)) - 256;
      else s = centre + int'($urandom_range(40)) - 20;
      if (s > 255) s = 255;
      if (s < -256) s = -256;
      send_cmd(act, s, $urandom_range(7) != 0, $urandom_range(15));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: field extremes, each action, the documented corner cases
    send_cmd(ACT_CYCLE, -256, 1, 0);
    send_cmd(ACT_CYCLE, 255, 1, 15);
    send_cmd(ACT_CYCLE, 100, 0, 1);
    send_cmd(ACT_SET, 0, 0, 0);
    send_cmd(ACT_SET, 0, 0, 11);
    send_cmd(ACT_SET, 0, 0, 10);
    send_cmd(ACT_SET, 0, 0, 2);
    send_cmd(ACT_NEXT, 0, 0, 0);
    send_cmd(ACT_NEXT, 0, 0, 0);
    send_cmd(ACT_AUTO, 0, 0, 0);
    send_cmd(ACT_MANUAL, 0, 0, 0);
    send_cmd(ACT_MANUAL, 0, 0, 0);
    send_cmd(ACT_DOWN, 0, 0, 0);
    for (int k = 0; k < 25; k++) send_cmd(ACT_UP, 0, 0, 0);
    send_cmd(ACT_CYCLE, 40, 1, 0);
    send_cmd(ACT_TOGGLE, 0, 0, 0);
    send_cmd(ACT_DOWN, 0, 0, 0);
    send_cmd(ACT_OFF, 0, 0, 0);
    send_cmd(ACT_NEXT, 0, 0, 0);
    send_cmd(ACT_TOGGLE, 0, 0, 0);
    send_cmd(ACT_UP, 0, 0, 0);
    send_cmd(ACT_CYCLE, 7, 1, 0);
    send_cmd(ACT_ON, 0, 0, 0);
    send_cmd(ACT_TICK, 0, 0, 0);
    for (int a = 11; a < 16; a++) send_cmd(action_t'(a), 0, 1, 15);

    // phase with large gains and a long timeout
    write_all(32767, 32767, 32767, 0, 65535, 32767, 255, 4095);
    random_cmds(300, 120);
    // phase with zero gains and a wide band
    write_all(0, 0, 0, 15, 65535, 1, 0, 0);
    random_cmds(250, 0);
    // moderate settings
    write_all(120, 10, 100, 1, 60000, 20000, 128, 1000);
    random_cmds(400, 40);
    write_all($urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
              $urandom_range(15), 65535, $urandom_range(1, 32767), $urandom_range(255),
              $urandom_range(4095));
    random_cmds(300, 60);
    // short timeout, then zero, so the sticky fault gets raised
    write_all(200, 20, 50, 2, 30, 20000, 200, 500);
    random_cmds(150, -100);
    write_reg(CFG_TIMEOUT, 0);
    random_cmds(120, 150);

    @(negedge clk);
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("sent %0d command beats over six register settings, %0d result beats checked",
             sent, results_seen);
    $display("covered all actions, mode changes, off and on, nudges and the timeout fault");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
